// ----- src/tcf_pkg.sv -----
`timescale 1ns / 1ps
// Package for the tagged chunk finder: result record and header position codes.
// Used by tagged_chunk_finder and tcf_checker; depends on nothing else.
package tcf_pkg;

  localparam logic STATUS_FOUND     = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  localparam logic [3:0] HDR_TAG_FIRST  = 4'd0;
  localparam logic [3:0] HDR_LEN_FIRST  = 4'd4;
  localparam logic [3:0] HDR_LEN_LAST   = 4'd7;
  localparam logic [3:0] HDR_SKIP       = 4'd8;

  typedef struct packed {
    logic        status;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
  } result_t;

endpackage

// ----- src/tagged_chunk_finder.sv -----
`timescale 1ns / 1ps
// Each result is registered before it appears on the out_ port.
// Throughput: one byte beat per cycle; in_stall rises only when a result is held in
// the output register and a second one in the skid register.
// Reset (rst_n low, synchronous) clears the target tag, the scan state and the valid
// flags of both result registers. Depends on tcf_pkg.
module tagged_chunk_finder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [31:0] out_payload_offset,
  output logic [31:0] out_payload_length
);

  logic [31:0] target_tag_r;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        done_r, done_nxt;

  tcf_pkg::result_t res;
  logic             res_vld;
  tcf_pkg::result_t out_r, skid_r;
  logic             out_vld_r, skid_vld_r;

  logic accept;
  logic out_free;
  logic [31:0] len_full;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_vld_r || !out_stall;
  assign in_stall = skid_vld_r;

  always_comb begin
    len_full = len_r;
    case (hdr_idx_r[1:0])
      2'd0: len_full[7:0]   = in_data_byte;
      2'd1: len_full[15:8]  = in_data_byte;
      2'd2: len_full[23:16] = in_data_byte;
      default: len_full[31:24] = in_data_byte;
    endcase
  end

  always_comb begin
    hdr_idx_nxt = hdr_idx_r;
    tag_nxt     = tag_r;
    len_nxt     = len_r;
    skip_nxt    = skip_r;
    pos_nxt     = pos_r + 32'd1;
    done_nxt    = done_r;
    res_vld     = 1'b0;
    res.status         = tcf_pkg::STATUS_FOUND;
    res.payload_offset = pos_nxt;
    res.payload_length = len_full;

    if (!done_r) begin
      if (hdr_idx_r < tcf_pkg::HDR_LEN_FIRST) begin
        if (hdr_idx_r == tcf_pkg::HDR_TAG_FIRST) begin
          tag_nxt = {24'd0, in_data_byte};
          len_nxt = '0;
        end else begin
          case (hdr_idx_r[1:0])
            2'd1: tag_nxt[15:8]  = in_data_byte;
            2'd2: tag_nxt[23:16] = in_data_byte;
            default: tag_nxt[31:24] = in_data_byte;
          endcase
        end
        hdr_idx_nxt = hdr_idx_r + 4'd1;
      end else if (hdr_idx_r <= tcf_pkg::HDR_LEN_LAST) begin
        len_nxt     = len_full;
        hdr_idx_nxt = hdr_idx_r + 4'd1;
        if (hdr_idx_r == tcf_pkg::HDR_LEN_LAST) begin
          if (tag_r == target_tag_r) begin
            res_vld  = 1'b1;
            done_nxt = 1'b1;
          end else if (len_full == 32'd0) begin
            hdr_idx_nxt = tcf_pkg::HDR_TAG_FIRST;
          end else begin
            skip_nxt = len_full;
          end
        end
      end else if (hdr_idx_r == tcf_pkg::HDR_SKIP) begin
        skip_nxt = skip_r - 32'd1;
        if (skip_r == 32'd1) begin
          hdr_idx_nxt = tcf_pkg::HDR_TAG_FIRST;
        end
      end else begin
        hdr_idx_nxt = tcf_pkg::HDR_TAG_FIRST;
      end
    end

    if (in_last_byte) begin
      if (!done_nxt) begin
        res_vld            = 1'b1;
        res.status         = tcf_pkg::STATUS_NOT_FOUND;
        res.payload_offset = '0;
        res.payload_length = '0;
      end
      hdr_idx_nxt = tcf_pkg::HDR_TAG_FIRST;
      tag_nxt     = '0;
      len_nxt     = '0;
      skip_nxt    = '0;
      pos_nxt     = '0;
      done_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_tag_r <= '0;
      hdr_idx_r    <= tcf_pkg::HDR_TAG_FIRST;
      tag_r        <= '0;
      len_r        <= '0;
      skip_r       <= '0;
      pos_r        <= '0;
      done_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        target_tag_r <= cfg_wr_data;
      end
      if (accept) begin
        hdr_idx_r <= hdr_idx_nxt;
        tag_r     <= tag_nxt;
        len_r     <= len_nxt;
        skip_r    <= skip_nxt;
        pos_r     <= pos_nxt;
        done_r    <= done_nxt;
      end
    end
  end

  // The skid register catches a result while the output register is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_free) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (accept && res_vld) begin
      if (out_free) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_free) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_free) begin
        out_r <= skid_r;
      end
    end else if (accept && res_vld) begin
      if (out_free) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = out_r.status;
  assign out_payload_offset = out_r.payload_offset;
  assign out_payload_length = out_r.payload_length;

endmodule

// ----- src/tcf_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for tagged_chunk_finder, attached by the bind at the end.
// Depends on tcf_pkg.
module tcf_port_asserts (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_status,
  input logic [31:0] out_payload_offset,
  input logic [31:0] out_payload_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_status) && $stable(out_payload_offset)
      && $stable(out_payload_length))
    else $error("stalled result beat changed");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tcf_pkg::STATUS_NOT_FOUND |->
      out_payload_offset == 32'd0 && out_payload_length == 32'd0)
    else $error("not-found result carries nonzero fields");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled result");

endmodule

bind tagged_chunk_finder tcf_port_asserts u_tcf_port_asserts (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_payload_offset (out_payload_offset),
  .out_payload_length (out_payload_length)
);

// ----- tb/tcf_checker.sv -----
`timescale 1ns / 1ps
// Checker for the tagged chunk finder: watches the configuration port and both beat
// channels, predicts each search result and compares it field by field.
// Depends on tcf_pkg.
module tcf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_status,
  input  logic [31:0] out_payload_offset,
  input  logic [31:0] out_payload_length,
  output int          error_count,
  output int          pending_count
);

  tcf_pkg::result_t awaited_results[$];
  logic [31:0] wanted_tag;
  logic [3:0]  hdr_pos;
  logic [31:0] tag_acc;
  logic [31:0] len_acc;
  logic [31:0] skip_left;
  logic [31:0] stream_pos;
  logic        found_flag;

  initial begin
    error_count = 0;
    pending_count = 0;
  end

  task automatic clear_scan();
    hdr_pos = tcf_pkg::HDR_TAG_FIRST;
    tag_acc = '0;
    len_acc = '0;
    skip_left = '0;
    stream_pos = '0;
    found_flag = 1'b0;
  endtask

  task automatic scan_beat(input logic [7:0] data, input logic last);
    tcf_pkg::result_t res;
    stream_pos = stream_pos + 32'd1;
    if (!found_flag) begin
      if (hdr_pos < tcf_pkg::HDR_LEN_FIRST) begin
        if (hdr_pos == tcf_pkg::HDR_TAG_FIRST) begin
          tag_acc = '0;
          len_acc = '0;
        end
        tag_acc = tag_acc | (32'(data) << (8 * hdr_pos));
        hdr_pos = hdr_pos + 4'd1;
      end else if (hdr_pos <= tcf_pkg::HDR_LEN_LAST) begin
        len_acc = len_acc | (32'(data) << (8 * (hdr_pos - tcf_pkg::HDR_LEN_FIRST)));
        hdr_pos = hdr_pos + 4'd1;
        if (hdr_pos == tcf_pkg::HDR_SKIP) begin
          if (tag_acc == wanted_tag) begin
            res.status = tcf_pkg::STATUS_FOUND;
            res.payload_offset = stream_pos;
            res.payload_length = len_acc;
            awaited_results = {awaited_results, res};
            found_flag = 1'b1;
          end else if (len_acc == 32'd0) begin
            hdr_pos = tcf_pkg::HDR_TAG_FIRST;
          end else begin
            skip_left = len_acc;
          end
        end
      end else if (hdr_pos == tcf_pkg::HDR_SKIP) begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 32'd0) begin
          hdr_pos = tcf_pkg::HDR_TAG_FIRST;
        end
      end else begin
        hdr_pos = tcf_pkg::HDR_TAG_FIRST;
      end
    end
    if (last) begin
      if (!found_flag) begin
        res.status = tcf_pkg::STATUS_NOT_FOUND;
        res.payload_offset = '0;
        res.payload_length = '0;
        awaited_results = {awaited_results, res};
      end
      clear_scan();
    end
  endtask

  task automatic check_result();
    tcf_pkg::result_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result: status %0d, payload_offset %0d, payload_length %0d",
             out_status, out_payload_offset, out_payload_length);
      error_count++;
    end else begin
      want = awaited_results.pop_front();
      if (out_status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_status);
        error_count++;
      end
      if (out_payload_offset !== want.payload_offset) begin
        $error("payload_offset: expected %0d, got %0d", want.payload_offset,
               out_payload_offset);
        error_count++;
      end
      if (out_payload_length !== want.payload_length) begin
        $error("payload_length: expected %0d, got %0d", want.payload_length,
               out_payload_length);
        error_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      wanted_tag = '0;
      clear_scan();
      awaited_results.delete();
    end else begin
      if (cfg_wr_en) begin
        wanted_tag = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        scan_beat(in_data_byte, in_last_byte);
      end
      if (out_valid && !out_stall) begin
        check_result();
      end
    end
    pending_count <= awaited_results.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the tagged chunk finder testbench: clock, reset, chunked byte streams,
// result back-pressure and the verdict. Depends on tagged_chunk_finder and tcf_checker.
module testbench;

  localparam int PHASE_BEATS = 165;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_status;
  logic [31:0] out_payload_offset;
  logic [31:0] out_payload_length;

  int          error_count;
  int          pending;
  int          cycle_count = 0;
  int          beats_sent = 0;
  int          send_pace = 0;
  int          take_pace = 0;
  logic        press_req = 1'b0;
  bit          press_done = 1'b0;
  logic [31:0] current_target = '0;
  logic [7:0]  stream_bytes[$];

  tagged_chunk_finder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length)
  );

  tcf_checker result_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length),
    .error_count        (error_count),
    .pending_count      (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_wait(input int pace);
    case (pace)
      0: return 0;
      1: return $urandom_range(0, 13);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 13) : 0;
    endcase
  endfunction

  task automatic send_beat(input logic [7:0] data, input logic last);
    int gap;
    gap = draw_wait(send_pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic add_header(input logic [31:0] tag, input logic [31:0] len);
    for (int i = 0; i < 4; i++) stream_bytes = {stream_bytes, tag[8*i +: 8]};
    for (int i = 0; i < 4; i++) stream_bytes = {stream_bytes, len[8*i +: 8]};
  endtask

  task automatic add_filler(input int count);
    repeat (count) stream_bytes = {stream_bytes, 8'($urandom)};
  endtask

  task automatic send_stream();
    int n;
    n = stream_bytes.size();
    send_pace = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) send_beat(stream_bytes[i], i == n - 1);
    beats_sent += n;
    stream_bytes.delete();
  endtask

  function automatic logic [31:0] near_tag();
    case ($urandom_range(0, 4))
      0: return current_target ^ (32'd1 << $urandom_range(0, 31));
      1: return current_target ^ (32'hFF << (8 * $urandom_range(0, 3)));
      2: return current_target;
      default: return $urandom;
    endcase
  endfunction

  task automatic build_random_stream();
    int shape;
    int cut;
    logic [31:0] len;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      add_filler($urandom_range(1, 20));
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 5))
        0: len = 32'd0;
        5: len = $urandom;
        default: len = $urandom_range(1, 6);
      endcase
      add_header(near_tag(), len);
      add_filler(len > 32'd6 ? $urandom_range(0, 4) : int'(len));
    end
    if (shape <= 6) begin
      add_header(current_target, $urandom);
      add_filler($urandom_range(0, 3));
    end else begin
      add_header(current_target, $urandom);
      cut = $urandom_range(1, stream_bytes.size() - 1);
      while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    current_target = value;
  endtask

  initial begin : result_sink
    int hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (press_req && !press_done) begin
        press_done = 1'b1;
        hold = HOLD_OFF_CYCLES;
      end else begin
        if ($urandom_range(0, 15) == 0) take_pace = $urandom_range(0, 2);
        hold = draw_wait(take_pace);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [31:0] targets[5];
    int phase_start;
    int stream_n;
    targets = '{32'hFFFF_FFFF, $urandom, 32'h0000_0000, $urandom, 32'h8000_0001};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The target is still zero from reset here.
    add_header(32'h0000_0000, 32'hFFFF_FFFF);
    send_stream();
    stream_bytes = {stream_bytes, 8'hFF};
    send_stream();
    add_header(32'h0403_0201, 32'd1);
    add_filler(1);
    add_header(32'h0000_0000, 32'd0);
    stream_bytes = {stream_bytes, 8'h00};
    send_stream();

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      write_target(targets[p]);
      phase_start = beats_sent;
      stream_n = 0;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if (p == 1 && stream_n == 3) press_req <= 1'b1;
        build_random_stream();
        send_stream();
        stream_n++;
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tcf_pkg.sv
src/tagged_chunk_finder.sv
src/tcf_checker.sv
tb/tcf_checker.sv
tb/testbench.sv
